// File: design/hashed_index_color_hsv_to_rgb_assert.svh
// Assertion macros shared by the hashed index color pipeline.
// Depends on nothing; each user module provides clk and rst.
`ifndef HASHED_INDEX_COLOR_HSV_TO_RGB_ASSERT_SVH
`define HASHED_INDEX_COLOR_HSV_TO_RGB_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define HIHSV_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hihsv: implication check failed");
// Next-cycle implication.
`define HIHSV_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hihsv: next-cycle check failed");
`else
`define HIHSV_ASSERT_IMP(name, ante, cons)
`define HIHSV_ASSERT_NXT(name, ante, cons)
`endif
`endif

// File: design/hihsv_pkg.sv
// Shared constants and types for the hashed index color pipeline.
// No dependencies.
package hihsv_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MESH_W        = 16;
  localparam int SECT_W        = 12;
  localparam int CHAN_W        = 16;

  localparam logic [31:0] HASH_MESH_MUL = 32'h9E37_79B9;
  localparam logic [31:0] HASH_SECT_MUL = 32'h85EB_CA6B;
  localparam logic [31:0] HASH_XOR      = 32'hC2B2_AE35;

  // Fractions in thousandths, scaled to Q0.FRAC_BITS where used.
  localparam longint unsigned HUE_MESH_MILLI = 173;
  localparam longint unsigned HUE_SECT_MILLI = 327;
  localparam longint unsigned SAT_BASE_MILLI = 650;
  localparam longint unsigned SAT_SPAN_MILLI = 250;
  localparam longint unsigned VAL_BASE_MILLI = 780;
  localparam longint unsigned VAL_SPAN_MILLI = 180;

  // Hue sector, floor(hue * 6).
  typedef enum logic [2:0] {
    SEC_R_TO_Y = 3'd0,
    SEC_Y_TO_G = 3'd1,
    SEC_G_TO_C = 3'd2,
    SEC_C_TO_B = 3'd3,
    SEC_B_TO_M = 3'd4,
    SEC_M_TO_R = 3'd5
  } sector_t;

endpackage

// File: design/hihsv_hash.sv
// Hash and fraction scaling stages (two register stages).
// Depends on hihsv_pkg.
module hihsv_hash #(
  parameter int FRAC_BITS = hihsv_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [hihsv_pkg::MESH_W-1:0] mesh_index,
  input  logic [hihsv_pkg::SECT_W-1:0] section_index,
  output logic                        out_valid,
  output logic [FRAC_BITS:0]          hue_frac,
  output logic [FRAC_BITS:0]          sat_frac,
  output logic [FRAC_BITS:0]          val_frac,
  output logic [FRAC_BITS-1:0]        hue_lin
);

  localparam int F = FRAC_BITS;
  localparam int MW = hihsv_pkg::MESH_W;
  localparam int SW = hihsv_pkg::SECT_W;
  localparam logic [63:0] ONE64 = 64'd1 << F;
  localparam logic [F-1:0] K_MESH =
    F'((64'(hihsv_pkg::HUE_MESH_MILLI) * ONE64 + 64'd500) / 64'd1000);
  localparam logic [F-1:0] K_SECT =
    F'((64'(hihsv_pkg::HUE_SECT_MILLI) * ONE64 + 64'd500) / 64'd1000);
  localparam int R16_W = F + 17;
  localparam int R8_W  = F + 25;
  localparam logic [R16_W-1:0] RCP_65535 =
    R16_W'(((64'd1 << (32 + F)) + 64'd32767) / 64'd65535);
  localparam logic [R8_W-1:0] RCP_255 =
    R8_W'(((64'd1 << (32 + F)) + 64'd127) / 64'd255);

  // Stage A: index products.
  logic [31:0]     mesh_inc;
  logic [31:0]     sect_inc;
  logic [F+MW-1:0] mesh_prod;
  logic [F+SW-1:0] sect_prod;
  logic            a_valid;
  logic [31:0]     a_hm;
  logic [31:0]     a_hs;
  logic [F-1:0]    a_lm;
  logic [F-1:0]    a_ls;

  assign mesh_inc  = 32'(mesh_index) + 32'd1;
  assign sect_inc  = 32'(section_index) + 32'd1;
  assign mesh_prod = (F+MW)'(mesh_index) * (F+MW)'(K_MESH);
  assign sect_prod = (F+SW)'(section_index) * (F+SW)'(K_SECT);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_hm <= mesh_inc * hihsv_pkg::HASH_MESH_MUL;
    a_hs <= sect_inc * hihsv_pkg::HASH_SECT_MUL;
    a_lm <= mesh_prod[F-1:0];
    a_ls <= sect_prod[F-1:0];
  end

  // Stage B: combine hash, scale its fields by the reciprocals.
  logic [31:0]  hash;
  logic [F+32:0] hue_prod;
  logic [F+32:0] sat_prod;
  logic [F+32:0] val_prod;

  assign hash     = a_hm ^ a_hs ^ hihsv_pkg::HASH_XOR;
  assign hue_prod = (F+33)'(hash[15:0]) * (F+33)'(RCP_65535);
  assign sat_prod = (F+33)'(hash[15:8]) * (F+33)'(RCP_255);
  assign val_prod = (F+33)'(hash[23:16]) * (F+33)'(RCP_255);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    hue_frac <= hue_prod[F+32:32];
    sat_frac <= sat_prod[F+32:32];
    val_frac <= val_prod[F+32:32];
    hue_lin  <= a_lm + a_ls;
  end

endmodule

// File: design/hihsv_hsv.sv
// HSV formation and sector split stages (two register stages).
// Depends on hihsv_pkg and the assertion header.
`include "hashed_index_color_hsv_to_rgb_assert.svh"
module hihsv_hsv #(
  parameter int FRAC_BITS = hihsv_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [FRAC_BITS:0]    hue_frac,
  input  logic [FRAC_BITS:0]    sat_frac,
  input  logic [FRAC_BITS:0]    val_frac,
  input  logic [FRAC_BITS-1:0]  hue_lin,
  output logic                  out_valid,
  output hihsv_pkg::sector_t    sector,
  output logic [FRAC_BITS-1:0]  sat_f,
  output logic [FRAC_BITS:0]    sat_cf,
  output logic [FRAC_BITS:0]    sat_inv,
  output logic [FRAC_BITS-1:0]  val
);

  localparam int F = FRAC_BITS;
  localparam logic [63:0] ONE64 = 64'd1 << F;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [F-1:0] K_SAT_BASE =
    F'((64'(hihsv_pkg::SAT_BASE_MILLI) * ONE64 + 64'd500) / 64'd1000);
  localparam logic [F-1:0] K_SAT_SPAN =
    F'((64'(hihsv_pkg::SAT_SPAN_MILLI) * ONE64 + 64'd500) / 64'd1000);
  localparam logic [F-1:0] K_VAL_BASE =
    F'((64'(hihsv_pkg::VAL_BASE_MILLI) * ONE64 + 64'd500) / 64'd1000);
  localparam logic [F-1:0] K_VAL_SPAN =
    F'((64'(hihsv_pkg::VAL_SPAN_MILLI) * ONE64 + 64'd500) / 64'd1000);

  // Stage C: wrap hue, map bytes into the saturation and value bands.
  logic [2*F:0] sat_prod;
  logic [2*F:0] val_prod;
  logic [F:0]   sat_sum;
  logic [F:0]   val_sum;
  logic         c_valid;
  logic [F-1:0] c_hue;
  logic [F-1:0] c_sat;
  logic [F-1:0] c_val;

  assign sat_prod = (2*F+1)'(sat_frac) * (2*F+1)'(K_SAT_SPAN);
  assign val_prod = (2*F+1)'(val_frac) * (2*F+1)'(K_VAL_SPAN);
  assign sat_sum  = (F+1)'(K_SAT_BASE) + sat_prod[2*F:F];
  assign val_sum  = (F+1)'(K_VAL_BASE) + val_prod[2*F:F];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= in_valid;
    end
  end

  // Both bands stay below one, so the top bit of each sum is always clear.
  always_ff @(posedge clk) begin
    c_hue <= hue_frac[F-1:0] + hue_lin;
    c_sat <= sat_sum[F-1:0];
    c_val <= val_sum[F-1:0];
  end

  // Stage D: split hue*6 into sector and fraction, form the sat products.
  logic [F+2:0]   hue6;
  logic [F-1:0]   frac;
  logic [F:0]     frac_inv;
  logic [2*F-1:0] sf_prod;
  logic [2*F:0]   sg_prod;

  assign hue6     = (F+3)'({c_hue, 2'b00}) + (F+3)'({c_hue, 1'b0});
  assign frac     = hue6[F-1:0];
  assign frac_inv = ONE - (F+1)'(frac);
  assign sf_prod  = (2*F)'(c_sat) * (2*F)'(frac);
  assign sg_prod  = (2*F+1)'(c_sat) * (2*F+1)'(frac_inv);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    sector  <= hihsv_pkg::sector_t'(hue6[F+2:F]);
    sat_f   <= sf_prod[2*F-1:F];
    sat_cf  <= sg_prod[2*F:F];
    sat_inv <= ONE - (F+1)'(c_sat);
    val     <= c_val;
  end

  // Hue below one keeps hue*6 below six.
  `HIHSV_ASSERT_IMP(a_sector_range, out_valid, sector <= hihsv_pkg::SEC_M_TO_R)

endmodule

// File: design/hihsv_rgb.sv
// p/q/t products and sector select with output register (two stages).
// Depends on hihsv_pkg and the assertion header.
`include "hashed_index_color_hsv_to_rgb_assert.svh"
module hihsv_rgb #(
  parameter int FRAC_BITS = hihsv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  hihsv_pkg::sector_t           sector,
  input  logic [FRAC_BITS-1:0]         sat_f,
  input  logic [FRAC_BITS:0]           sat_cf,
  input  logic [FRAC_BITS:0]           sat_inv,
  input  logic [FRAC_BITS-1:0]         val,
  output logic                         done,
  output logic [hihsv_pkg::CHAN_W-1:0] red,
  output logic [hihsv_pkg::CHAN_W-1:0] green,
  output logic [hihsv_pkg::CHAN_W-1:0] blue
);

  localparam int F  = FRAC_BITS;
  localparam int CW = hihsv_pkg::CHAN_W;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // Stage E: p, q and t, each no larger than value.
  logic [F:0]         q_mul;
  logic [F:0]         t_mul;
  logic [2*F:0]       p_prod;
  logic [2*F:0]       q_prod;
  logic [2*F:0]       t_prod;
  logic               e_valid;
  hihsv_pkg::sector_t e_sector;
  logic [F-1:0]       e_val;
  logic [F-1:0]       e_p;
  logic [F-1:0]       e_q;
  logic [F-1:0]       e_t;

  assign q_mul  = ONE - (F+1)'(sat_f);
  assign t_mul  = ONE - sat_cf;
  assign p_prod = (2*F+1)'(val) * (2*F+1)'(sat_inv);
  assign q_prod = (2*F+1)'(val) * (2*F+1)'(q_mul);
  assign t_prod = (2*F+1)'(val) * (2*F+1)'(t_mul);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else begin
      e_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    e_sector <= sector;
    e_val    <= val;
    e_p      <= p_prod[2*F-1:F];
    e_q      <= q_prod[2*F-1:F];
    e_t      <= t_prod[2*F-1:F];
  end

  // Stage F: pick channels by sector, rescale to Q0.16.
  logic [F-1:0]  r_sel;
  logic [F-1:0]  g_sel;
  logic [F-1:0]  b_sel;
  logic [CW-1:0] red_next;
  logic [CW-1:0] green_next;
  logic [CW-1:0] blue_next;

  always_comb begin
    case (e_sector)
      hihsv_pkg::SEC_R_TO_Y: begin
        r_sel = e_val; g_sel = e_t;   b_sel = e_p;
      end
      hihsv_pkg::SEC_Y_TO_G: begin
        r_sel = e_q;   g_sel = e_val; b_sel = e_p;
      end
      hihsv_pkg::SEC_G_TO_C: begin
        r_sel = e_p;   g_sel = e_val; b_sel = e_t;
      end
      hihsv_pkg::SEC_C_TO_B: begin
        r_sel = e_p;   g_sel = e_q;   b_sel = e_val;
      end
      hihsv_pkg::SEC_B_TO_M: begin
        r_sel = e_t;   g_sel = e_p;   b_sel = e_val;
      end
      default: begin
        r_sel = e_val; g_sel = e_p;   b_sel = e_q;
      end
    endcase
  end

  generate
    if (F >= CW) begin : g_narrow
      assign red_next   = r_sel[F-1:F-CW];
      assign green_next = g_sel[F-1:F-CW];
      assign blue_next  = b_sel[F-1:F-CW];
    end else begin : g_widen
      assign red_next   = {r_sel, {(CW-F){1'b0}}};
      assign green_next = {g_sel, {(CW-F){1'b0}}};
      assign blue_next  = {b_sel, {(CW-F){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  // Value scales every product by a factor of at most one.
  `HIHSV_ASSERT_IMP(a_pqt_bounded, e_valid, (e_p <= e_val) && (e_q <= e_val) && (e_t <= e_val))

endmodule

// File: design/hashed_index_color_hsv_to_rgb.sv
// Top level of the hashed index color generator: mesh/section index to RGB.
// Depends on hihsv_pkg, hihsv_hash, hihsv_hsv, hihsv_rgb, assertion header.
//
//  channel | ports                               | handshake
//  --------+-------------------------------------+------------------------------
//  input   | mesh_index, section_index           | beat taken when start && !busy
//  output  | red, green, blue                    | beat shown for one cycle, done
//
// Flow: one beat may enter every cycle while busy is low; each result passes
// through two hash stages, two HSV stages and two RGB stages (the last one
// being the output register).
// Reset: rst clears every valid bit; busy is high for the cycle after reset
// and low from then on.
// Stalls: the receiver cannot hold results off, so the pipeline never stalls
// and busy never rises outside reset.
`include "hashed_index_color_hsv_to_rgb_assert.svh"
module hashed_index_color_hsv_to_rgb #(
  parameter int FRAC_BITS = hihsv_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [hihsv_pkg::MESH_W-1:0] mesh_index,
  input  logic [hihsv_pkg::SECT_W-1:0] section_index,
  output logic                         done,
  output logic [hihsv_pkg::CHAN_W-1:0] red,
  output logic [hihsv_pkg::CHAN_W-1:0] green,
  output logic [hihsv_pkg::CHAN_W-1:0] blue
);

  localparam int F = FRAC_BITS;

  logic accept;

  // Hold off beats only while coming out of reset.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept = start && !busy;

  // Hash stage outputs.
  logic         h_valid;
  logic [F:0]   h_hue_frac;
  logic [F:0]   h_sat_frac;
  logic [F:0]   h_val_frac;
  logic [F-1:0] h_hue_lin;

  // HSV stage outputs.
  logic               v_valid;
  hihsv_pkg::sector_t v_sector;
  logic [F-1:0]       v_sat_f;
  logic [F:0]         v_sat_cf;
  logic [F:0]         v_sat_inv;
  logic [F-1:0]       v_val;

  // Hash the indices and scale hash fields to fractions.
  hihsv_hash #(.FRAC_BITS(FRAC_BITS)) u_hash (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (accept),
    .mesh_index    (mesh_index),
    .section_index (section_index),
    .out_valid     (h_valid),
    .hue_frac      (h_hue_frac),
    .sat_frac      (h_sat_frac),
    .val_frac      (h_val_frac),
    .hue_lin       (h_hue_lin)
  );

  // Form hue, saturation and value; split hue into sector and fraction.
  hihsv_hsv #(.FRAC_BITS(FRAC_BITS)) u_hsv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (h_valid),
    .hue_frac  (h_hue_frac),
    .sat_frac  (h_sat_frac),
    .val_frac  (h_val_frac),
    .hue_lin   (h_hue_lin),
    .out_valid (v_valid),
    .sector    (v_sector),
    .sat_f     (v_sat_f),
    .sat_cf    (v_sat_cf),
    .sat_inv   (v_sat_inv),
    .val       (v_val)
  );

  // Six-sector conversion and output register.
  hihsv_rgb #(.FRAC_BITS(FRAC_BITS)) u_rgb (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v_valid),
    .sector   (v_sector),
    .sat_f    (v_sat_f),
    .sat_cf   (v_sat_cf),
    .sat_inv  (v_sat_inv),
    .val      (v_val),
    .done     (done),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  // Every taken beat yields exactly one result.
  `HIHSV_ASSERT_IMP(a_accept_to_done, accept, ##6 done)
  `HIHSV_ASSERT_IMP(a_done_from_accept, done, $past(start && !busy, 6))
  // Outside reset nothing holds the input side off.
  `HIHSV_ASSERT_NXT(a_never_busy, !rst, !busy)

endmodule
